>>> rtl/prewitt_vertical_edge_filter_core_defines.svh
// assertion macros used by the filter core
`ifndef PREWITT_VERTICAL_EDGE_FILTER_CORE_DEFINES_SVH
`define PREWITT_VERTICAL_EDGE_FILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PVEF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PVEF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PVEF_ASSERT_IMP(lbl, ante, cons, msg)
`define PVEF_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/pvef_pkg.sv
`timescale 1ns / 1ps
package pvef_pkg;

  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int SUM_W      = 10;
  localparam int DIFF_W     = 11;
  localparam int PROD_W     = 20;
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 2;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_FIFO_DEPTH = 8;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } reg_index_t;

  typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

  typedef struct packed {
    logic emit;
    logic frame_end;
  } stage_ctl_t;

  typedef struct packed {
    pix_t mag;
    logic frame_end;
  } res_t;

endpackage

>>> rtl/pvef_ifs.sv
`timescale 1ns / 1ps
interface pvef_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface pvef_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output frame_end, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input frame_end, output ready);
endinterface

>>> rtl/pvef_line_store.sv
`timescale 1ns / 1ps
module pvef_line_store
  import pvef_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEF_MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pix_t          wr_px,
  output pix_t          top,
  output pix_t          mid
);

  pix_t older_mem [DEPTH];
  pix_t newer_mem [DEPTH];

  // the middle row read last cycle moves up into the older line
  always_ff @(posedge clk) begin
    if (rd_en) begin
      top <= older_mem[rd_addr];
      mid <= newer_mem[rd_addr];
    end
    if (wr_en) begin
      older_mem[wr_addr] <= mid;
      newer_mem[wr_addr] <= wr_px;
    end
  end

endmodule

>>> rtl/pvef_gradient.sv
`timescale 1ns / 1ps
module pvef_gradient
  import pvef_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       valid,
  input  stage_ctl_t ctl,
  input  pix_t       top,
  input  pix_t       mid,
  input  pix_t       px,
  output logic       res_valid,
  output res_t       res
);

  logic [NUM_CH-1:0][SUM_W-1:0]         sum_c1;
  logic [NUM_CH-1:0][SUM_W-1:0]         sum_c2;
  logic [NUM_CH-1:0][SUM_W-1:0]         sum_new;
  logic [NUM_CH-1:0][DIFF_W-1:0]        diff_next;
  logic [NUM_CH-1:0][DIFF_W-1:0]        diff;
  logic [NUM_CH-1:0][SUM_W-1:0]         mag;
  logic [NUM_CH-1:0][PROD_W-1:0]        prod;
  logic                                 diff_valid;
  logic                                 diff_fe;
  logic                                 prod_fe;

  // column sums: newest column minus the one two places back
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      sum_new[k] = SUM_W'(top[k]) + SUM_W'(mid[k]) + SUM_W'(px[k]);
      diff_next[k] = {1'b0, sum_new[k]} - {1'b0, sum_c1[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_c1 <= '0;
      sum_c2 <= '0;
    end else if (valid) begin
      sum_c1 <= sum_c2;
      sum_c2 <= sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      diff_valid <= valid && ctl.emit;
      res_valid  <= diff_valid;
    end
  end

  always_ff @(posedge clk) begin
    diff    <= diff_next;
    diff_fe <= ctl.frame_end;
    for (int k = 0; k < NUM_CH; k++) begin
      prod[k] <= PROD_W'(mag[k]) * PROD_W'(DIV3_MUL);
    end
    prod_fe <= diff_fe;
  end

  // abs, then divide by 3 through the reciprocal multiply
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      if (diff[k][DIFF_W-1]) begin
        mag[k] = SUM_W'(~diff[k] + DIFF_W'(1));
      end else begin
        mag[k] = diff[k][SUM_W-1:0];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      res.mag[k] = prod[k][DIV3_SHIFT +: CH_W];
    end
    res.frame_end = prod_fe;
  end

endmodule

>>> rtl/pvef_out_fifo.sv
`timescale 1ns / 1ps
module pvef_out_fifo
  import pvef_pkg::*;
#(
  parameter int DEPTH = DEF_FIFO_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  pvef_pix_out_if.source pix_out
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign pop = pix_out.valid && pix_out.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  assign pix_out.valid     = (count != '0);
  assign pix_out.out_red   = mem[rd_ptr].mag[0];
  assign pix_out.out_green = mem[rd_ptr].mag[1];
  assign pix_out.out_blue  = mem[rd_ptr].mag[2];
  assign pix_out.frame_end = mem[rd_ptr].frame_end;

endmodule

>>> rtl/prewitt_vertical_edge_filter_core.sv
`timescale 1ns / 1ps
// Prewitt horizontal-gradient edge filter on a raster RGB pixel stream.
// pix_in takes one pixel per item in raster order; pix_out gives one item
// per interior pixel (row 2 or later and column 2 or later of the input),
// with frame_end set on the last one of the frame. Border pixels give none.
// cfg_we/cfg_index/cfg_data write image_width (index 0) or image_height
// (index 1); either write restarts the frame. Write only while idle.
// Throughput: one pixel per clock while pix_in.ready is high, set by the
// single read/modify/write pass through the two line-store memories (read
// at accept, written back the next cycle at that column). A result
// passes the s1, difference and product registers before the output fifo.
// Results wait in an output fifo of FIFO_DEPTH items; pix_in.ready drops
// once FIFO_DEPTH results are outstanding, so a stalled receiver holds the
// input back after that many and nothing is lost.
// Reset: sizes return to 640 x 480, counters and window clear; line stores
// are not cleared, their contents only feed rows that give no result.
`include "prewitt_vertical_edge_filter_core_defines.svh"
module prewitt_vertical_edge_filter_core
  import pvef_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  pvef_pix_in_if.sink            pix_in,
  pvef_pix_out_if.source         pix_out,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int OW = $clog2(FIFO_DEPTH + 1);

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [CW-1:0]           col_count;
  logic [RW-1:0]           row_count;
  logic [CW-1:0]           col_count_next;
  logic [RW-1:0]           row_count_next;
  logic [31:0]             w_eff;
  logic [31:0]             h_eff;
  logic [31:0]             w_m1;
  logic [31:0]             h_m1;
  logic [CW-1:0]           w_last;
  logic [RW-1:0]           h_last;
  logic                    in_acc;
  logic                    out_acc;
  logic                    restart;
  pix_t                    in_px;
  stage_ctl_t              in_ctl;
  logic                    s1_valid;
  stage_ctl_t              s1_ctl;
  pix_t                    s1_px;
  logic [CW-1:0]           s1_col;
  pix_t                    ls_top;
  pix_t                    ls_mid;
  logic                    res_valid;
  res_t                    res;
  logic [OW-1:0]           outstanding;

  assign in_acc  = pix_in.valid && pix_in.ready;
  assign out_acc = pix_out.valid && pix_out.ready;
  assign in_px   = {pix_in.blue, pix_in.green, pix_in.red};
  assign restart = cfg_we && ((cfg_index == REG_IMAGE_WIDTH) ||
                              (cfg_index == REG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the frame size into the supported range
  always_comb begin
    w_eff = 32'(image_width);
    if (w_eff < 32'd3) begin
      w_eff = 32'd3;
    end else if (w_eff > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end
    h_eff = 32'(image_height);
    if (h_eff < 32'd3) begin
      h_eff = 32'd3;
    end else if (h_eff > 32'(MAX_HEIGHT)) begin
      h_eff = 32'(MAX_HEIGHT);
    end
    w_m1   = w_eff - 32'd1;
    h_m1   = h_eff - 32'd1;
    w_last = w_m1[CW-1:0];
    h_last = h_m1[RW-1:0];
  end

  always_comb begin
    col_count_next = col_count + CW'(1);
    row_count_next = row_count;
    if (col_count == w_last) begin
      col_count_next = '0;
      row_count_next = (row_count == h_last) ? '0 : row_count + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_acc) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  assign in_ctl.emit      = (row_count >= RW'(2)) && (col_count >= CW'(2));
  assign in_ctl.frame_end = (row_count == h_last) && (col_count == w_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl <= in_ctl;
    s1_px  <= in_px;
    s1_col <= col_count;
  end

  pvef_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_count),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_px   (s1_px),
    .top     (ls_top),
    .mid     (ls_mid)
  );

  pvef_gradient u_gradient (
    .clk       (clk),
    .rst       (rst),
    .valid     (s1_valid),
    .ctl       (s1_ctl),
    .top       (ls_top),
    .mid       (ls_mid),
    .px        (s1_px),
    .res_valid (res_valid),
    .res       (res)
  );

  pvef_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pix_out   (pix_out)
  );

  // results in flight or queued
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + OW'(in_acc && in_ctl.emit) - OW'(out_acc);
    end
  end

  assign pix_in.ready = (outstanding < OW'(FIFO_DEPTH));

  `PVEF_ASSERT_IMP(a_no_rw_same_col, s1_valid && in_acc, s1_col != col_count, "rw column clash")
  `PVEF_ASSERT_IMP(a_out_has_credit, pix_out.valid, outstanding != '0, "output with no credit")
  `PVEF_ASSERT_IMP(a_credit_bound, 1'b1, outstanding <= OW'(FIFO_DEPTH), "credit overflow")
  `PVEF_ASSERT_NXT(a_frame_wrap, in_acc && in_ctl.frame_end, ~|{row_count, col_count}, "no wrap")

endmodule
